>>> rtl/cfe_pkg.sv
`default_nettype none
package cfe_pkg;

  localparam int NUM_BUCKETS      = 1024;
  localparam int KICK_ROUNDS      = 16;
  localparam int KICKS_PER_ROUND  = 32;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int TAG_W            = 32;
  localparam int FP_W             = 64;
  localparam int GEN_W            = 64;
  localparam int CNT_W            = 13;
  localparam int OP_W             = 2;
  localparam int BKT_W            = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
  localparam int ROW_W            = TAG_W * SLOTS_PER_BUCKET;
  localparam int RND_W            = (KICK_ROUNDS > 1) ? $clog2(KICK_ROUNDS) : 1;
  localparam int KCK_W            = (KICKS_PER_ROUND > 1) ? $clog2(KICKS_PER_ROUND) : 1;
  localparam int PADDR_W          = 4;
  localparam int PDATA_W          = 64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Register index taken from paddr[3] (8-byte register spacing).
  localparam logic REG_SEED = 1'b0;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
    logic [FP_W-1:0] fp;
  } cfe_req_t;

  typedef struct packed {
    logic             valid;
    logic             success;
    logic [CNT_W-1:0] count;
  } cfe_res_t;

  function automatic logic [GEN_W-1:0] xorshift_step(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] a;
    logic [GEN_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

endpackage
`default_nettype wire

>>> rtl/cfe_xorshift.sv
`default_nettype none
module cfe_xorshift
  import cfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [GEN_W-1:0] seed,
  input  logic             advance,
  output logic [GEN_W-1:0] gen_next
);

  logic [GEN_W-1:0] gen;

  assign gen_next = xorshift_step(gen);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= GEN_W'(1);
    end else if (load) begin
      // A zero seed would lock the generator at zero.
      gen <= (seed == '0) ? GEN_W'(1) : seed;
    end else if (advance) begin
      gen <= gen_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfe_engine.sv
`default_nettype none
module cfe_engine
  import cfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfe_req_t         req,
  input  logic             res_take,
  input  logic [GEN_W-1:0] gen_next,
  output logic             idle,
  output logic             gen_adv,
  output cfe_res_t         res
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CLR  = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_CHK1 = 10'b0000001000,
    S_RD2  = 10'b0000010000,
    S_CHK2 = 10'b0000100000,
    S_KICK = 10'b0001000000,
    S_RDK  = 10'b0010000000,
    S_CHKK = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [OP_W-1:0]  op_r;
  logic [TAG_W-1:0] tag, tag_next;
  logic [BKT_W-1:0] bkt, bkt_next;
  logic [GEN_W-1:0] sel, sel_next;
  logic [RND_W-1:0] rnd, rnd_next;
  logic [KCK_W-1:0] kck, kck_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [BKT_W-1:0] clr_addr, clr_addr_next;
  logic             clr_reply, clr_reply_next;
  logic             ok, ok_next;

  logic [ROW_W-1:0] mem [NUM_BUCKETS];
  logic [ROW_W-1:0] rdata;
  logic             mem_we, mem_re;
  logic [BKT_W-1:0] mem_addr;
  logic [ROW_W-1:0] wdata;

  logic [TAG_W-1:0]  in_tag;
  logic              empty_hit, tag_hit;
  logic [SLOT_W-1:0] empty_idx;
  logic [TAG_W-1:0]  held;

  always_comb begin
    in_tag = req.fp[TAG_W-1:0];
    if (in_tag == '0) begin
      in_tag = req.fp[FP_W-1:TAG_W] | TAG_W'(1);
    end
  end

  // First empty slot, and tag match, over the bucket just read.
  always_comb begin
    empty_hit = 1'b0;
    empty_idx = '0;
    tag_hit   = 1'b0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (rdata[i*TAG_W +: TAG_W] == '0) begin
        empty_hit = 1'b1;
        empty_idx = SLOT_W'(i);
      end
      if (rdata[i*TAG_W +: TAG_W] == tag) begin
        tag_hit = 1'b1;
      end
    end
  end

  assign held = rdata[sel[SLOT_W-1:0]*TAG_W +: TAG_W];

  always_comb begin
    state_next     = state;
    tag_next       = tag;
    bkt_next       = bkt;
    sel_next       = sel;
    rnd_next       = rnd;
    kck_next       = kck;
    cnt_next       = cnt;
    clr_addr_next  = clr_addr;
    clr_reply_next = clr_reply;
    ok_next        = ok;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = bkt;
    wdata          = rdata;
    gen_adv        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          tag_next = in_tag;
          bkt_next = req.fp[TAG_W +: BKT_W];
          ok_next  = 1'b0;
          if (req.op == OP_CLEAR) begin
            clr_addr_next  = '0;
            clr_reply_next = 1'b1;
            state_next     = S_CLR;
          end else if (req.op == OP_INSERT || req.op == OP_TEST) begin
            state_next = S_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
        wdata    = '0;
        if (clr_addr == BKT_W'(NUM_BUCKETS - 1)) begin
          cnt_next   = '0;
          ok_next    = 1'b1;
          state_next = clr_reply ? S_DONE : S_IDLE;
        end else begin
          clr_addr_next = clr_addr + BKT_W'(1);
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_CHK1;
      end
      S_CHK1: begin
        if (op_r == OP_TEST) begin
          if (tag_hit) begin
            ok_next    = 1'b1;
            state_next = S_DONE;
          end else begin
            bkt_next   = bkt ^ tag[BKT_W-1:0];
            state_next = S_RD2;
          end
        end else if (empty_hit) begin
          mem_we                         = 1'b1;
          wdata[empty_idx*TAG_W +: TAG_W] = tag;
          ok_next                        = 1'b1;
          cnt_next                       = cnt + CNT_W'(1);
          state_next                     = S_DONE;
        end else begin
          bkt_next   = bkt ^ tag[BKT_W-1:0];
          state_next = S_RD2;
        end
      end
      S_RD2: begin
        mem_re     = 1'b1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        if (op_r == OP_TEST) begin
          ok_next    = tag_hit;
          state_next = S_DONE;
        end else if (empty_hit) begin
          mem_we                         = 1'b1;
          wdata[empty_idx*TAG_W +: TAG_W] = tag;
          ok_next                        = 1'b1;
          cnt_next                       = cnt + CNT_W'(1);
          state_next                     = S_DONE;
        end else begin
          gen_adv    = 1'b1;
          sel_next   = gen_next;
          rnd_next   = '0;
          kck_next   = '0;
          state_next = S_KICK;
        end
      end
      S_KICK: begin
        // The bucket in rdata is full; swap the tag in hand into the chosen slot.
        mem_we                                 = 1'b1;
        wdata[sel[SLOT_W-1:0]*TAG_W +: TAG_W] = tag;
        tag_next                               = held;
        bkt_next                               = bkt ^ held[BKT_W-1:0];
        sel_next                               = sel >> SLOT_W;
        state_next                             = S_RDK;
      end
      S_RDK: begin
        mem_re     = 1'b1;
        state_next = S_CHKK;
      end
      S_CHKK: begin
        if (empty_hit) begin
          mem_we                         = 1'b1;
          wdata[empty_idx*TAG_W +: TAG_W] = tag;
          ok_next                        = 1'b1;
          cnt_next                       = cnt + CNT_W'(1);
          state_next                     = S_DONE;
        end else if (kck == KCK_W'(KICKS_PER_ROUND - 1)) begin
          if (rnd == RND_W'(KICK_ROUNDS - 1)) begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end else begin
            rnd_next   = rnd + RND_W'(1);
            kck_next   = '0;
            gen_adv    = 1'b1;
            sel_next   = gen_next;
            state_next = S_KICK;
          end
        end else begin
          kck_next   = kck + KCK_W'(1);
          state_next = S_KICK;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      cnt       <= '0;
      ok        <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      clr_reply <= clr_reply_next;
      cnt       <= cnt_next;
      ok        <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) begin
      op_r <= req.op;
    end
    tag <= tag_next;
    bkt <= bkt_next;
    sel <= sel_next;
    rnd <= rnd_next;
    kck <= kck_next;
  end

  assign idle        = (state == S_IDLE);
  assign res.valid   = (state == S_DONE);
  assign res.success = ok;
  assign res.count   = cnt;

`ifndef NO_ASSERTIONS
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || state == S_CHK1 || state == S_CHK2 ||
                state == S_KICK || state == S_CHKK))
    else $error("bucket write outside a write state");

  a_kick_reads: assert property (@(posedge clk) disable iff (rst)
    state == S_KICK |=> state == S_RDK)
    else $error("kick not followed by a bucket read");

  a_tag_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_KICK || state == S_CHKK) |-> tag != '0)
    else $error("empty tag in hand during eviction");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NUM_BUCKETS * SLOTS_PER_BUCKET))
    else $error("tag count above store capacity");
`endif

endmodule
`default_nettype wire

>>> rtl/cuckoo_filter_engine_core.sv
`default_nettype none
// Channel   Handshake              Beat contents
// input     in_valid / in_stall    opcode, fingerprint
// output    out_valid / out_stall  success, stored_count
// config    APB, pready tied high  random_seed at byte address 0
//
// A test or plain insert reads and checks the home bucket (S_RD, S_CHK1); if that
// bucket does not decide it, the alternate is read and checked too (one memory port).
// Each eviction kick adds a write, a read and a check; at most 512 kicks per insert.
// Clear zeroes every bucket row and the count, one bucket row cleared per cycle.
// After reset a clearing pass over every bucket runs before the first beat is taken.
// A finished result waits in the output register while the next beat is accepted.
module cuckoo_filter_engine_core
  import cfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    opcode,
  input  logic [FP_W-1:0]    fingerprint,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               success,
  output logic [CNT_W-1:0]   stored_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [GEN_W-1:0] random_seed;
  logic             seed_wr;
  logic             idle;
  logic             gen_adv;
  logic [GEN_W-1:0] gen_next;
  logic             res_take;
  cfe_req_t         req;
  cfe_res_t         res;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[3] == REG_SEED);
  assign prdata  = (paddr[3] == REG_SEED) ? random_seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      random_seed <= GEN_W'(1);
    end else if (seed_wr) begin
      random_seed <= pwdata;
    end
  end

  cfe_xorshift u_gen (
    .clk      (clk),
    .rst      (rst),
    .load     (seed_wr),
    .seed     (pwdata),
    .advance  (gen_adv),
    .gen_next (gen_next)
  );

  assign in_stall  = !idle;
  assign req.start = in_valid && idle;
  assign req.op    = opcode;
  assign req.fp    = fingerprint;

  cfe_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_take (res_take),
    .gen_next (gen_next),
    .idle     (idle),
    .gen_adv  (gen_adv),
    .res      (res)
  );

  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      success      <= res.success;
      stored_count <= res.count;
    end
  end

endmodule
`default_nettype wire
